// ===== design/stip_pkg.sv =====
package stip_pkg;

  localparam int STRING_LENGTH_MAX = 4095;
  localparam int POS_W = $clog2(STRING_LENGTH_MAX + 1);

  localparam int VALUE_W = 64;
  localparam int BASE_W = 6;
  localparam int DIGIT_W = 6;
  localparam int SUM_W = VALUE_W + BASE_W + 1;

  localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = DIGIT_W'(36);

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    OVF_NONE,
    OVF_MAX,
    OVF_MIN
  } ovf_t;

  typedef enum logic [1:0] {
    BSEL_KEEP,
    BSEL_8,
    BSEL_10,
    BSEL_16
  } base_sel_t;

  typedef struct packed {
    logic      take;
    logic      finish;
    logic      set_neg;
    logic      mark_zero;
    logic      take_digit;
    base_sel_t base_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic base_bad;
    logic is_space;
    logic is_sign;
    logic is_zero;
    logic is_x;
    logic auto_base;
    logic hex_base;
    logic d_lt_eff;
    logic d_lt_8;
    logic d_lt_10;
    logic d_lt_16;
  } dp_status_t;

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = DIGIT_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = DIGIT_W'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = DIGIT_W'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

// ===== design/stip_ctrl.sv =====
module stip_ctrl
  import stip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  phase_t phase;
  phase_t phase_next;
  logic   accept;
  logic   after_sign;
  logic   dig;
  logic   dig_ok;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    cmd = '0;
    cmd.take = accept;
    cmd.base_sel = BSEL_KEEP;
    after_sign = 1'b0;
    dig = 1'b0;
    dig_ok = 1'b0;
    if (accept) begin
      if (st.base_bad) begin
        phase_next = PH_DONE;
      end else begin
        unique case (phase)
          PH_SPACE: begin
            if (st.is_sign) begin
              cmd.set_neg = 1'b1;
              phase_next = PH_SIGN;
            end else if (!st.is_space) begin
              after_sign = 1'b1;
            end
          end
          PH_SIGN: begin
            after_sign = 1'b1;
          end
          PH_ZERO: begin
            if (st.is_x) begin
              phase_next = PH_XSEEN;
            end else begin
              if (st.auto_base) begin
                cmd.base_sel = BSEL_8;
              end
              dig = 1'b1;
              dig_ok = st.auto_base ? st.d_lt_8 : st.d_lt_eff;
            end
          end
          PH_XSEEN: begin
            if (st.d_lt_16) begin
              cmd.base_sel = BSEL_16;
              dig = 1'b1;
              dig_ok = 1'b1;
            end else begin
              phase_next = PH_DONE;
            end
          end
          PH_DIGITS: begin
            dig = 1'b1;
            dig_ok = st.d_lt_eff;
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
        if (after_sign) begin
          if ((st.auto_base || st.hex_base) && st.is_zero) begin
            cmd.mark_zero = 1'b1;
            phase_next = PH_ZERO;
          end else begin
            if (st.auto_base) begin
              cmd.base_sel = BSEL_10;
            end
            dig = 1'b1;
            dig_ok = st.auto_base ? st.d_lt_10 : st.d_lt_eff;
          end
        end
        if (dig) begin
          if (dig_ok) begin
            cmd.take_digit = 1'b1;
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      if (last) begin
        cmd.finish = 1'b1;
        phase_next = PH_SPACE;
      end
    end
  end

endmodule

// ===== design/stip_dp.sv =====
module stip_dp
  import stip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic [BASE_W-1:0]         base_select,
  input  logic [7:0]                ch,
  input  dp_cmd_t                   cmd,
  output dp_status_t                st,
  output logic signed [VALUE_W-1:0] value,
  output logic [1:0]                status,
  output logic [11:0]               end_offset
);

  logic [BASE_W-1:0]  base_in_use;
  logic               negative;
  logic [VALUE_W-1:0] accumulator;
  ovf_t               overflow_kind;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   end_position;
  logic               saw_digit;

  logic [BASE_W-1:0]  eff_base;
  logic [BASE_W-1:0]  base_next;
  logic [DIGIT_W-1:0] digit;
  logic               first;
  logic [POS_W-1:0]   position_next;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   limit;
  logic               over;
  logic               negative_next;
  logic [VALUE_W-1:0] accumulator_next;
  ovf_t               overflow_kind_next;
  logic [POS_W-1:0]   end_position_next;
  logic               saw_digit_next;

  logic [VALUE_W-1:0] res_acc;
  logic               res_neg;
  ovf_t               res_ovf;
  logic               res_saw;
  logic [POS_W-1:0]   res_end;

  assign first = (position == '0);
  assign eff_base = first ? base_select : base_in_use;
  assign digit = digit_value(ch);
  assign position_next = (position < POS_W'(STRING_LENGTH_MAX)) ? position + POS_W'(1) : position;

  always_comb begin
    st.base_bad = first && (base_select == BASE_W'(1) || base_select > BASE_MAX);
    st.is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    st.is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
    st.is_zero = (ch == CH_ZERO);
    st.is_x = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
    st.auto_base = (eff_base == BASE_AUTO);
    st.hex_base = (eff_base == BASE_W'(16));
    st.d_lt_eff = (BASE_W'(digit) < eff_base);
    st.d_lt_8 = (digit < DIGIT_W'(8));
    st.d_lt_10 = (digit < DIGIT_W'(10));
    st.d_lt_16 = (digit < DIGIT_W'(16));
  end

  always_comb begin
    unique case (cmd.base_sel)
      BSEL_8:  base_next = BASE_W'(8);
      BSEL_10: base_next = BASE_W'(10);
      BSEL_16: base_next = BASE_W'(16);
      default: base_next = eff_base;
    endcase
  end

  assign sum = SUM_W'(accumulator) * SUM_W'(base_next) + SUM_W'(digit);
  assign limit = negative ? SUM_W'(VALUE_MIN) : SUM_W'(VALUE_MAX);
  assign over = (sum > limit);

  always_comb begin
    negative_next = negative;
    accumulator_next = accumulator;
    overflow_kind_next = overflow_kind;
    end_position_next = end_position;
    saw_digit_next = saw_digit;
    if (cmd.set_neg) begin
      negative_next = (ch == CH_MINUS);
    end
    if (cmd.mark_zero || cmd.take_digit) begin
      saw_digit_next = 1'b1;
      end_position_next = position_next;
    end
    if (cmd.take_digit && overflow_kind == OVF_NONE) begin
      if (over) begin
        overflow_kind_next = negative ? OVF_MIN : OVF_MAX;
      end else begin
        accumulator_next = sum[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_in_use <= BASE_AUTO;
      negative <= 1'b0;
      accumulator <= '0;
      overflow_kind <= OVF_NONE;
      position <= '0;
      end_position <= '0;
      saw_digit <= 1'b0;
    end else if (cmd.take) begin
      if (cmd.finish) begin
        base_in_use <= BASE_AUTO;
        negative <= 1'b0;
        accumulator <= '0;
        overflow_kind <= OVF_NONE;
        position <= '0;
        end_position <= '0;
        saw_digit <= 1'b0;
      end else begin
        base_in_use <= base_next;
        negative <= negative_next;
        accumulator <= accumulator_next;
        overflow_kind <= overflow_kind_next;
        position <= position_next;
        end_position <= end_position_next;
        saw_digit <= saw_digit_next;
      end
    end
  end

  // hold the finished item until taken
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_acc <= accumulator_next;
      res_neg <= negative_next;
      res_ovf <= overflow_kind_next;
      res_saw <= saw_digit_next;
      res_end <= end_position_next;
    end
  end

  always_comb begin
    if (!res_saw) begin
      value = '0;
      status = STATUS_INVALID;
      end_offset = '0;
    end else begin
      end_offset = 12'(res_end);
      unique case (res_ovf)
        OVF_MAX: begin
          value = VALUE_MAX;
          status = STATUS_RANGE;
        end
        OVF_MIN: begin
          value = VALUE_MIN;
          status = STATUS_RANGE;
        end
        default: begin
          value = res_neg ? -res_acc : res_acc;
          status = STATUS_OK;
        end
      endcase
    end
  end

endmodule

// ===== design/string_to_integer_parser.sv =====
// Parses a string into a signed 64-bit integer, strtol style. Each input item carries one
// character; the item with last set closes the string and yields one result (value,
// status, end_offset), all other items yield none. Leading whitespace and one sign are
// taken, base_select (APB, address 0) picks base 2..36 or 0 for automatic prefix detection
// (0x/0X hex, leading 0 octal, else decimal); it is sampled at the first character of each
// string. Overflow saturates with status 1; no digits or a bad base give status 2. One item
// is accepted per cycle; the multiply-add and limit compare of the accumulator are
// combinational. The result is valid the cycle after the last character is taken and
// waits in an output register; input stalls while it waits, until the cycle it is taken.
module string_to_integer_parser
  import stip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                ch,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic [1:0]                status,
  output logic [11:0]               end_offset
);

  logic [BASE_W-1:0] base_select;
  dp_cmd_t           cmd;
  dp_status_t        st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(base_select) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= BASE_AUTO;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      base_select <= pwdata[BASE_W-1:0];
    end
  end

  stip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  stip_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .base_select (base_select),
    .ch          (ch),
    .cmd         (cmd),
    .st          (st),
    .value       (value),
    .status      (status),
    .end_offset  (end_offset)
  );

endmodule
